// ===== rtl/lc3x_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_pkg
// shared opcodes, condition code constants, write-port types and helpers
// for the lc3 execute unit
// ----------------------------------------------------------------------------
package lc3x_pkg;

	typedef enum logic [3:0] {
		OPC_BR   = 4'h0,
		OPC_ADD  = 4'h1,
		OPC_LD   = 4'h2,
		OPC_ST   = 4'h3,
		OPC_JSR  = 4'h4,
		OPC_AND  = 4'h5,
		OPC_LDR  = 4'h6,
		OPC_STR  = 4'h7,
		OPC_RTI  = 4'h8,
		OPC_NOT  = 4'h9,
		OPC_LDI  = 4'hA,
		OPC_STI  = 4'hB,
		OPC_JMP  = 4'hC,
		OPC_RES  = 4'hD,
		OPC_LEA  = 4'hE,
		OPC_TRAP = 4'hF
	} opcode_t;

	localparam logic [2:0] CC_N     = 3'b100;
	localparam logic [2:0] CC_Z     = 3'b010;
	localparam logic [2:0] CC_P     = 3'b001;
	localparam logic [2:0] CC_RESET = CC_Z;

	localparam logic [2:0] LINK_REG = 3'd7;

	// register file write port
	typedef struct packed {
		logic        we;
		logic [2:0]  sel;
		logic [15:0] data;
	} rf_wr_t;

	// word memory write port, full 16-bit address
	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [15:0] data;
	} mem_wr_t;

	// one result item
	typedef struct packed {
		logic [15:0] next_pc;
		logic [2:0]  cond_code;
		logic        reg_we;
		logic [2:0]  reg_sel;
		logic [15:0] reg_value;
		logic        mem_we;
		logic [15:0] mem_addr;
		logic [15:0] mem_value;
		logic        illegal;
	} res_item_t;

	function automatic logic [15:0] sext5(input logic [4:0] x);
		return {{11{x[4]}}, x};
	endfunction

	function automatic logic [15:0] sext6(input logic [5:0] x);
		return {{10{x[5]}}, x};
	endfunction

	function automatic logic [15:0] sext9(input logic [8:0] x);
		return {{7{x[8]}}, x};
	endfunction

	function automatic logic [15:0] sext11(input logic [10:0] x);
		return {{5{x[10]}}, x};
	endfunction

	function automatic logic [2:0] nzp_of(input logic [15:0] v);
		logic [2:0] cc;
		if (v == 16'h0000) begin
			cc = CC_Z;
		end else if (v[15]) begin
			cc = CC_N;
		end else begin
			cc = CC_P;
		end
		return cc;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lc3x_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_if
// valid/ready channels of the lc3 execute unit: request and result
// ----------------------------------------------------------------------------
interface lc3x_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] instr;
	logic [15:0] pc;
	logic [15:0] load_addr;
	logic [15:0] load_data;

	modport source (output valid, op, instr, pc, load_addr, load_data, input ready);
	modport sink   (input valid, op, instr, pc, load_addr, load_data, output ready);
endinterface

interface lc3x_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] next_pc;
	logic [2:0]  cond_code;
	logic        reg_we;
	logic [2:0]  reg_sel;
	logic [15:0] reg_value;
	logic        mem_we;
	logic [15:0] mem_addr;
	logic [15:0] mem_value;
	logic        illegal;

	modport source (output valid, next_pc, cond_code, reg_we, reg_sel, reg_value,
		mem_we, mem_addr, mem_value, illegal, input ready);
	modport sink   (input valid, next_pc, cond_code, reg_we, reg_sel, reg_value,
		mem_we, mem_addr, mem_value, illegal, output ready);
endinterface
`default_nettype wire

// ===== rtl/lc3_execute_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_execute_unit
// executes one lc3 instruction word (or a word-memory load) per request and
// returns one result holding next pc, condition codes and the writes done
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       payload
//  req       in    valid / ready   op, instr, pc, load_addr, load_data
//  result    out   valid / ready   next_pc, cond_code, reg_we, reg_sel,
//                                  reg_value, mem_we, mem_addr, mem_value,
//                                  illegal
//
//  cycles: one request per cycle unless stalled; ldr and ldi pass the execute stage
//  and then the second read stage; their second memory read waits on registered
//  data of the first read or the reg file; the result is held in a result register
//  reset: registers read as zero through valid bits, flags start at z, no clearing
//  pass for the word memory, so req.ready is high right after reset
//  stalls: a result not taken holds the finishing stage, which drops req.ready
//
module lc3_execute_unit import lc3x_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lc3x_req_if.sink  req,
	lc3x_res_if.source result
);

	// ------------------------------------------------------------------
	// handshake and stage control
	// ------------------------------------------------------------------
	logic        accept;
	logic        out_free;
	logic        s1_long;
	logic        s1_adv;
	logic        s1_done;
	logic        s2_done;

	// execute stage
	logic        valid_s1;
	logic        op_s1;
	logic [15:0] instr_s1;
	logic [15:0] pc_s1;
	logic [15:0] laddr_s1;
	logic [15:0] ldata_s1;

	// second memory read stage (ldr / ldi only)
	logic        valid_s2;
	logic [2:0]  dr_s2;
	logic [15:0] pc_s2;

	logic [2:0]  flags_q;
	logic        out_valid_q;
	res_item_t   out_q;

	// storage ports
	rf_wr_t      rf_wr;
	mem_wr_t     mem_wr;
	logic [2:0]  rf_b_sel;
	logic [15:0] rf_a_data;
	logic [15:0] rf_b_data;
	logic [15:0] mem_a_addr;
	logic [15:0] mem_a_data;
	logic [15:0] mem_b_addr;
	logic [15:0] mem_b_data;

	opcode_t     req_opc;
	opcode_t     opc_s1;

	// execute stage decode results
	logic [15:0] pc_off9;
	logic [15:0] base_off6;
	logic [15:0] alu_b;
	logic [15:0] s1_npc;
	logic        s1_rwe;
	logic [2:0]  s1_rsel;
	logic [15:0] s1_rval;
	logic        s1_setcc;
	logic        s1_store;
	logic [15:0] s1_ea;
	logic        s1_ill;

	res_item_t   s1_res;
	res_item_t   s2_res;

	assign req_opc = opcode_t'(req.instr[15:12]);
	assign opc_s1  = opcode_t'(instr_s1[15:12]);

	assign out_free = !out_valid_q || result.ready;
	assign s1_long  = valid_s1 && !op_s1 && ((opc_s1 == OPC_LDR) || (opc_s1 == OPC_LDI));
	assign s1_adv   = s1_long;
	assign s1_done  = valid_s1 && !s1_long && out_free;
	assign s2_done  = valid_s2 && out_free;

	// next request may enter when the stage ahead finishes in this cycle;
	// its reads then see that stage's writes through the bypass
	assign req.ready = (!valid_s1 || s1_done) && (!valid_s2 || s2_done);
	assign accept    = req.valid && req.ready;

	// ------------------------------------------------------------------
	// read addresses issued at acceptance
	// ------------------------------------------------------------------
	always_comb begin
		case (req_opc) inside
			OPC_ST, OPC_STI, OPC_STR: rf_b_sel = req.instr[11:9];
			default:                  rf_b_sel = req.instr[2:0];
		endcase
	end

	assign mem_a_addr = req.pc + sext9(req.instr[8:0]);

	// ldr reads at base + offset, ldi at the pointer fetched by port a
	assign mem_b_addr = (opc_s1 == OPC_LDR) ? base_off6 : mem_a_data;

	lc3x_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (rf_wr),
		.rd_en     (accept),
		.rd_a_sel  (req.instr[8:6]),
		.rd_b_sel  (rf_b_sel),
		.rd_a_data (rf_a_data),
		.rd_b_data (rf_b_data)
	);

	lc3x_wordmem #(
		.ADDR_BITS (ADDR_BITS)
	) u_wordmem (
		.clk       (clk),
		.wr        (mem_wr),
		.rd_a_en   (accept),
		.rd_a_addr (mem_a_addr),
		.rd_a_data (mem_a_data),
		.rd_b_en   (s1_adv),
		.rd_b_addr (mem_b_addr),
		.rd_b_data (mem_b_data)
	);

	// ------------------------------------------------------------------
	// pipeline registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_done || s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= req.op;
			instr_s1 <= req.instr;
			pc_s1    <= req.pc;
			laddr_s1 <= req.load_addr;
			ldata_s1 <= req.load_data;
		end
		if (s1_adv) begin
			dr_s2 <= instr_s1[11:9];
			pc_s2 <= pc_s1;
		end
	end

	// ------------------------------------------------------------------
	// execute stage
	// ------------------------------------------------------------------
	assign pc_off9   = pc_s1 + sext9(instr_s1[8:0]);
	assign base_off6 = rf_a_data + sext6(instr_s1[5:0]);
	assign alu_b     = instr_s1[5] ? sext5(instr_s1[4:0]) : rf_b_data;

	always_comb begin
		s1_npc   = pc_s1;
		s1_rwe   = 1'b0;
		s1_rsel  = instr_s1[11:9];
		s1_rval  = '0;
		s1_setcc = 1'b0;
		s1_store = 1'b0;
		s1_ea    = pc_off9;
		s1_ill   = 1'b0;
		if (!op_s1) begin
			unique case (opc_s1) inside
				OPC_BR: begin
					if ((instr_s1[11:9] & flags_q) != 3'b000) begin
						s1_npc = pc_off9;
					end
				end
				OPC_ADD: begin
					s1_rwe   = 1'b1;
					s1_setcc = 1'b1;
					s1_rval  = rf_a_data + alu_b;
				end
				OPC_AND: begin
					s1_rwe   = 1'b1;
					s1_setcc = 1'b1;
					s1_rval  = rf_a_data & alu_b;
				end
				OPC_NOT: begin
					s1_rwe   = 1'b1;
					s1_setcc = 1'b1;
					s1_rval  = ~rf_a_data;
				end
				OPC_LD: begin
					s1_rwe   = 1'b1;
					s1_setcc = 1'b1;
					s1_rval  = mem_a_data;
				end
				OPC_LEA: begin
					s1_rwe  = 1'b1;
					s1_rval = pc_off9;
				end
				OPC_ST: begin
					s1_store = 1'b1;
				end
				OPC_STI: begin
					s1_store = 1'b1;
					s1_ea    = mem_a_data;
				end
				OPC_STR: begin
					s1_store = 1'b1;
					s1_ea    = base_off6;
				end
				OPC_JSR: begin
					// target comes from the old r7 when jsrr links through it
					s1_npc  = instr_s1[11] ? (pc_s1 + sext11(instr_s1[10:0])) : rf_a_data;
					s1_rwe  = 1'b1;
					s1_rsel = LINK_REG;
					s1_rval = pc_s1;
				end
				OPC_JMP: begin
					s1_npc = rf_a_data;
				end
				OPC_LDR, OPC_LDI: begin
					// finished in the second read stage
				end
				default: begin
					s1_ill = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		s1_res           = '0;
		s1_res.next_pc   = s1_npc;
		s1_res.cond_code = s1_setcc ? nzp_of(s1_rval) : flags_q;
		s1_res.reg_we    = s1_rwe;
		s1_res.reg_sel   = s1_rwe ? s1_rsel : '0;
		s1_res.reg_value = s1_rval;
		s1_res.mem_we    = s1_store;
		s1_res.mem_addr  = s1_store ? 16'(s1_ea[ADDR_BITS-1:0]) : '0;
		s1_res.mem_value = s1_store ? rf_b_data : '0;
		s1_res.illegal   = s1_ill;
	end

	always_comb begin
		s2_res           = '0;
		s2_res.next_pc   = pc_s2;
		s2_res.cond_code = nzp_of(mem_b_data);
		s2_res.reg_we    = 1'b1;
		s2_res.reg_sel   = dr_s2;
		s2_res.reg_value = mem_b_data;
	end

	// ------------------------------------------------------------------
	// writes at completion
	// ------------------------------------------------------------------
	always_comb begin
		rf_wr.we   = (s1_done && s1_rwe) || s2_done;
		rf_wr.sel  = s2_done ? dr_s2 : s1_rsel;
		rf_wr.data = s2_done ? mem_b_data : s1_rval;
	end

	always_comb begin
		mem_wr.we   = s1_done && (op_s1 || s1_store);
		mem_wr.addr = op_s1 ? laddr_s1 : s1_ea;
		mem_wr.data = op_s1 ? ldata_s1 : rf_b_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= CC_RESET;
		end else if (s2_done) begin
			flags_q <= s2_res.cond_code;
		end else if (s1_done && s1_setcc) begin
			flags_q <= s1_res.cond_code;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done || s2_done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			out_q <= s2_res;
		end else if (s1_done) begin
			out_q <= s1_res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.next_pc   = out_q.next_pc;
	assign result.cond_code = out_q.cond_code;
	assign result.reg_we    = out_q.reg_we;
	assign result.reg_sel   = out_q.reg_sel;
	assign result.reg_value = out_q.reg_value;
	assign result.mem_we    = out_q.mem_we;
	assign result.mem_addr  = out_q.mem_addr;
	assign result.mem_value = out_q.mem_value;
	assign result.illegal   = out_q.illegal;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// the two stages never hold requests at once
	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("execute and read stages both occupied");

	// a long load in execute blocks the next request
	a_long_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_long |-> !req.ready)
		else $error("request taken behind ldr or ldi");

	// condition codes always hold exactly one of n, z, p
	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(flags_q))
		else $error("condition codes not one-hot");

	// the read stage fills only from a long load in execute
	a_s2_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(s1_adv))
		else $error("read stage filled without a long load");

endmodule
`default_nettype wire

// ===== rtl/lc3x_regfile.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_regfile
// eight 16-bit registers, one write port, two registered read ports
// with write-first bypass; per-entry valid bits give the zero reset value
// ----------------------------------------------------------------------------
module lc3x_regfile import lc3x_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rf_wr_t      wr,
	input  wire logic        rd_en,
	input  wire logic [2:0]  rd_a_sel,
	input  wire logic [2:0]  rd_b_sel,
	output logic      [15:0] rd_a_data,
	output logic      [15:0] rd_b_data
);

	logic [15:0] mem [8];
	logic [7:0]  valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.sel] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.sel] <= wr.data;
		end
	end

	// write-first: a write in the same cycle is seen by the read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.we && (wr.sel == rd_a_sel)) begin
				rd_a_data <= wr.data;
			end else begin
				rd_a_data <= valid_q[rd_a_sel] ? mem[rd_a_sel] : '0;
			end
			if (wr.we && (wr.sel == rd_b_sel)) begin
				rd_b_data <= wr.data;
			end else begin
				rd_b_data <= valid_q[rd_b_sel] ? mem[rd_b_sel] : '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lc3x_wordmem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_wordmem
// word memory of 2^ADDR_BITS x 16, one write port and two registered
// read ports; both ports bypass a write to the same word in the same cycle
// ----------------------------------------------------------------------------
module lc3x_wordmem import lc3x_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire mem_wr_t     wr,
	input  wire logic        rd_a_en,
	input  wire logic [15:0] rd_a_addr,
	output logic      [15:0] rd_a_data,
	input  wire logic        rd_b_en,
	input  wire logic [15:0] rd_b_addr,
	output logic      [15:0] rd_b_data
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr[ADDR_BITS-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_a_en) begin
			if (wr.we && (wr.addr[ADDR_BITS-1:0] == rd_a_addr[ADDR_BITS-1:0])) begin
				rd_a_data <= wr.data;
			end else begin
				rd_a_data <= mem[rd_a_addr[ADDR_BITS-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_b_en) begin
			if (wr.we && (wr.addr[ADDR_BITS-1:0] == rd_b_addr[ADDR_BITS-1:0])) begin
				rd_b_data <= wr.data;
			end else begin
				rd_b_data <= mem[rd_b_addr[ADDR_BITS-1:0]];
			end
		end
	end

endmodule
`default_nettype wire

// ===== verif/lc3_execute_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_execute_checker
// watches the request and result channels of the lc3 execute unit, keeps a
// shadow of its registers, flags and word memory, and compares every result
// with the one predicted for the oldest outstanding request
// ----------------------------------------------------------------------------
module lc3_execute_checker import lc3x_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	lc3x_req_if      req,
	lc3x_res_if      result,
	output int       fail_count,
	output int       pending
);

	localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 1);

	logic [15:0] gpr [8];
	logic [2:0]  flags;
	logic [15:0] word_mem [65536];
	res_item_t   expected_results [$];
	int          results_seen;

	function automatic logic [2:0] flags_for(input logic [15:0] v);
		if (v == 16'h0000) begin
			return CC_Z;
		end
		return v[15] ? CC_N : CC_P;
	endfunction

	function automatic logic [15:0] peek_word(input logic [15:0] a);
		return word_mem[a & ADDR_MASK];
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] lc3 result %0d: %s", $time, results_seen, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want) begin
			report_error($sformatf("%s got %h want %h", name, got, want));
		end
	endtask

	// architectural effect of one request, shadow state updated in place
	task automatic execute_request(input logic load_op, input logic [15:0] ins,
		input logic [15:0] pc, input logic [15:0] la, input logic [15:0] ld,
		output res_item_t r);
		logic [2:0]  dr;
		logic [2:0]  sr1;
		logic [15:0] operand;
		logic [15:0] ea;
		logic        update_cc;
		r = '0;
		r.next_pc = pc;
		update_cc = 1'b0;
		dr = ins[11:9];
		sr1 = ins[8:6];
		if (load_op) begin
			word_mem[la & ADDR_MASK] = ld;
		end else begin
			case (opcode_t'(ins[15:12]))
				OPC_BR: begin
					if ((dr & flags) != 3'b000) begin
						r.next_pc = pc + 16'($signed(ins[8:0]));
					end
				end
				OPC_ADD, OPC_AND: begin
					operand = ins[5] ? 16'($signed(ins[4:0])) : gpr[ins[2:0]];
					r.reg_value = (ins[15:12] == OPC_ADD) ? gpr[sr1] + operand
						: gpr[sr1] & operand;
					r.reg_we = 1'b1;
					r.reg_sel = dr;
					update_cc = 1'b1;
				end
				OPC_NOT: begin
					r.reg_value = ~gpr[sr1];
					r.reg_we = 1'b1;
					r.reg_sel = dr;
					update_cc = 1'b1;
				end
				OPC_LD, OPC_LDI: begin
					ea = pc + 16'($signed(ins[8:0]));
					r.reg_value = (ins[15:12] == OPC_LDI) ? peek_word(peek_word(ea))
						: peek_word(ea);
					r.reg_we = 1'b1;
					r.reg_sel = dr;
					update_cc = 1'b1;
				end
				OPC_LDR: begin
					r.reg_value = peek_word(gpr[sr1] + 16'($signed(ins[5:0])));
					r.reg_we = 1'b1;
					r.reg_sel = dr;
					update_cc = 1'b1;
				end
				OPC_LEA: begin
					r.reg_value = pc + 16'($signed(ins[8:0]));
					r.reg_we = 1'b1;
					r.reg_sel = dr;
				end
				OPC_ST, OPC_STI, OPC_STR: begin
					if (ins[15:12] == OPC_STR) begin
						ea = gpr[sr1] + 16'($signed(ins[5:0]));
					end else begin
						ea = pc + 16'($signed(ins[8:0]));
					end
					if (ins[15:12] == OPC_STI) begin
						ea = peek_word(ea);
					end
					r.mem_we = 1'b1;
					r.mem_addr = ea & ADDR_MASK;
					r.mem_value = gpr[dr];
					word_mem[r.mem_addr] = r.mem_value;
				end
				OPC_JSR: begin
					// target taken before the link write so jsrr r7 uses the old r7
					r.next_pc = ins[11] ? pc + 16'($signed(ins[10:0])) : gpr[sr1];
					r.reg_we = 1'b1;
					r.reg_sel = LINK_REG;
					r.reg_value = pc;
				end
				OPC_JMP: begin
					r.next_pc = gpr[sr1];
				end
				OPC_RTI, OPC_RES, OPC_TRAP: begin
					r.illegal = 1'b1;
				end
			endcase
			if (r.reg_we) begin
				gpr[r.reg_sel] = r.reg_value;
			end
			if (update_cc) begin
				flags = flags_for(r.reg_value);
			end
		end
		r.cond_code = flags;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_item_t got;
		res_item_t want;
		res_item_t predicted;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				gpr[i] = '0;
			end
			flags = CC_RESET;
			expected_results.delete();
			results_seen = 0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got = {result.next_pc, result.cond_code, result.reg_we, result.reg_sel,
					result.reg_value, result.mem_we, result.mem_addr, result.mem_value,
					result.illegal};
				if (expected_results.size() == 0) begin
					report_error("result with no request outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("next_pc", got.next_pc, want.next_pc);
					check_field("cond_code", 16'(got.cond_code), 16'(want.cond_code));
					check_field("reg_we", 16'(got.reg_we), 16'(want.reg_we));
					check_field("reg_sel", 16'(got.reg_sel), 16'(want.reg_sel));
					check_field("reg_value", got.reg_value, want.reg_value);
					check_field("mem_we", 16'(got.mem_we), 16'(want.mem_we));
					check_field("mem_addr", got.mem_addr, want.mem_addr);
					check_field("mem_value", got.mem_value, want.mem_value);
					check_field("illegal", 16'(got.illegal), 16'(want.illegal));
				end
				results_seen++;
			end
			if (req.valid && req.ready) begin
				execute_request(req.op, req.instr, req.pc, req.load_addr, req.load_data,
					predicted);
				expected_results.push_back(predicted);
			end
			pending <= expected_results.size();
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// drives the lc3 execute unit with a directed opening and then about nine
// hundred requests of random instruction words and memory loads, under three
// idling patterns; a checker beside the unit predicts and compares results
// ----------------------------------------------------------------------------
module tb import lc3x_pkg::*;;

	localparam int PHASE_ITEMS = 300;
	localparam int QUIET_LIMIT = 2000;

	typedef enum logic [2:0] {R0, R1, R2, R3, R4, R5, R6, R7} gpr_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   quiet_cycles;

	lc3x_req_if req ();
	lc3x_res_if result ();

	lc3_execute_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.result (result)
	);

	lc3_execute_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure, redrawn every cycle
	initial begin
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: any cycle without a handshake on either channel counts
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (result.valid && result.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL lc3_execute_unit");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one request; returns at the edge where it is accepted
	task automatic send(input logic op, input logic [15:0] instr, input logic [15:0] pc,
		input logic [15:0] la, input logic [15:0] ld);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.instr <= instr;
		req.pc <= pc;
		req.load_addr <= la;
		req.load_data <= ld;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// instruction request, load fields are don't-care noise
	task automatic issue_word(input logic [15:0] instr, input logic [15:0] pc);
		send(1'b0, instr, pc, 16'($urandom), 16'($urandom));
	endtask

	// memory load request, instruction fields are don't-care noise
	task automatic store_word(input logic [15:0] addr, input logic [15:0] data);
		send(1'b1, 16'($urandom), 16'($urandom), addr, data);
	endtask

	// runs any instruction word; memory reads get their words loaded first so
	// no read ever touches a location that was never written
	task automatic run_instruction(input logic [15:0] instr, input logic [15:0] pc);
		logic [15:0] ea;
		logic [15:0] ptr;
		logic [15:0] base;
		logic [8:0]  lea_off;
		ea = pc + 16'($signed(instr[8:0]));
		case (opcode_t'(instr[15:12]))
			OPC_LD: begin
				store_word(ea, 16'($urandom));
			end
			OPC_STI: begin
				store_word(ea, 16'($urandom));
			end
			OPC_LDI: begin
				// pointer must not land on itself, or the second load would clobber it
				do begin
					ptr = 16'($urandom);
				end while (ptr == ea);
				store_word(ea, ptr);
				store_word(ptr, 16'($urandom));
			end
			OPC_LDR: begin
				// lea sets the base register to a chosen value through its pc
				base = 16'($urandom);
				lea_off = 9'($urandom);
				issue_word({OPC_LEA, instr[8:6], lea_off}, base - 16'($signed(lea_off)));
				store_word(base + 16'($signed(instr[5:0])), 16'($urandom));
			end
			default: begin
			end
		endcase
		issue_word(instr, pc);
	endtask

	// one random step: mostly instruction words, with loads, read sequences and
	// store / load-back pairs mixed in
	task automatic random_step();
		opcode_t     read_op;
		logic [8:0]  off;
		logic [15:0] pc;
		int          pick;
		pick = $urandom_range(99);
		pc = 16'($urandom);
		off = 9'($urandom);
		if (pick < 15) begin
			store_word(16'($urandom), 16'($urandom));
		end else if (pick < 35) begin
			case ($urandom_range(3))
				0: read_op = OPC_LD;
				1: read_op = OPC_LDI;
				2: read_op = OPC_LDR;
				default: read_op = OPC_STI;
			endcase
			run_instruction({read_op, 12'($urandom)}, pc);
		end else if (pick < 45) begin
			// store a register then read the same word back
			issue_word({OPC_ST, 3'($urandom), off}, pc);
			issue_word({OPC_LD, 3'($urandom), off}, pc);
		end else begin
			run_instruction(16'($urandom), pc);
		end
	endtask

	initial begin
		req.valid <= 1'b0;
		req.op <= 1'b0;
		req.instr <= '0;
		req.pc <= '0;
		req.load_addr <= '0;
		req.load_data <= '0;
		arst_n <= 1'b0;
		sent = 0;
		send_idle_pct = 20;
		recv_stall_pct = 87;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		// branch on all flags right after reset, most negative offset wraps pc
		issue_word({OPC_BR, CC_N | CC_Z | CC_P, 9'h100}, 16'h0005);
		// branch with no condition bits is never taken
		issue_word({OPC_BR, 3'b000, 9'h0FF}, 16'hFFFF);
		// immediate extremes: +15 then -16
		issue_word({OPC_ADD, R1, R0, 1'b1, 5'h0F}, 16'h1000);
		issue_word({OPC_ADD, R2, R1, 1'b1, 5'h10}, 16'h1001);
		issue_word({OPC_AND, R3, R2, 1'b0, 2'b00, R1}, 16'h1002);
		issue_word({OPC_NOT, R4, R2, 6'h3F}, 16'h1003);
		// z is set: n-only branch falls through, z-only branch is taken
		issue_word({OPC_BR, CC_N, 9'h001}, 16'h2000);
		issue_word({OPC_BR, CC_Z, 9'h0FF}, 16'h2000);
		// lea wraps and leaves the flags alone
		issue_word({OPC_LEA, R5, 9'h0FF}, 16'hFFFF);
		issue_word({OPC_ADD, R6, R5, 1'b0, 2'b00, R2}, 16'h2001);
		// load through the top address, sign bit set
		store_word(16'hFFFF, 16'h8000);
		issue_word({OPC_LD, R0, 9'h1FF}, 16'h0000);
		// stores keep the flags, address arithmetic wraps to zero
		issue_word({OPC_ST, R1, 9'h0FF}, 16'hFF01);
		issue_word({OPC_STR, R2, R5, 6'h20}, 16'h3000);
		issue_word({OPC_LDR, R3, R5, 6'h20}, 16'h3001);
		run_instruction({OPC_STI, R6, 9'h100}, 16'h0100);
		run_instruction({OPC_LDI, R7, 9'h0FF}, 16'h1234);
		// subroutine calls: most negative offset, then jsrr through the link register
		issue_word({OPC_JSR, 1'b1, 11'h400}, 16'h0300);
		issue_word({OPC_JSR, 1'b0, 2'b00, LINK_REG, 6'h00}, 16'h4000);
		issue_word({OPC_JMP, 3'b000, LINK_REG, 6'h00}, 16'h5000);
		issue_word({OPC_JSR, 1'b1, 11'h3FF}, 16'hFC00);
		// illegal words are reported and otherwise ignored
		issue_word({OPC_RTI, 12'hFFF}, 16'h6000);
		issue_word({OPC_RES, 12'h000}, 16'h6001);
		issue_word({OPC_TRAP, 12'h025}, 16'h6002);

		// random part in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 20;
					recv_stall_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_stall_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			while (sent < (phase + 1) * PHASE_ITEMS) begin
				random_step();
			end
			if (phase == 0) begin
				// hold off new requests until the unit has drained completely
				req.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) begin
					@(posedge clk);
				end
			end
		end

		// drain, then keep watching for any stray result
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS lc3_execute_unit");
		end else begin
			$display("FAIL lc3_execute_unit");
		end
		$finish;
	end

endmodule
`default_nettype wire
